FILE: rtl/drb_pkg.sv
// Shared types and constants for the deque ring buffer core.
package drb_pkg;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_RESIZE     = 3'd6;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [5:0]         index;
    logic [6:0]         new_count;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [6:0]         count;
    logic               is_empty;
    logic               is_full;
    logic               underflow;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic push;
    logic at_front;
    logic pop;
    logic rd;
    logic clr;
    logic rsz;
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] value;
    logic [5:0]  index;
    logic [6:0]  new_count;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_FILL,
    B_READ,
    B_CAPT,
    B_EMIT
  } bst_t;

endpackage

FILE: rtl/drb_front.sv
// Front end: takes words on the start handshake and classifies the operation.
module drb_front (
  input  logic          start,
  input  drb_pkg::in_t  request,
  input  logic          q_full,
  output logic          busy,
  output logic          q_wr,
  output drb_pkg::job_t job
);

  drb_pkg::cls_t cls;

  always_comb begin
    cls = '0;
    case (request.operation)
      drb_pkg::OP_PUSH_BACK: begin
        cls.push = 1'b1;
      end
      drb_pkg::OP_PUSH_FRONT: begin
        cls.push     = 1'b1;
        cls.at_front = 1'b1;
      end
      drb_pkg::OP_POP_BACK: begin
        cls.pop = 1'b1;
      end
      drb_pkg::OP_POP_FRONT: begin
        cls.pop      = 1'b1;
        cls.at_front = 1'b1;
      end
      drb_pkg::OP_READ: begin
        cls.rd = 1'b1;
      end
      drb_pkg::OP_CLEAR: begin
        cls.clr = 1'b1;
      end
      drb_pkg::OP_RESIZE: begin
        cls.rsz = 1'b1;
      end
      default: begin
        cls = '0;
      end
    endcase
  end

  assign busy          = q_full;
  assign q_wr          = start && !q_full;
  assign job.cls       = cls;
  assign job.value     = request.value;
  assign job.index     = request.index;
  assign job.new_count = request.new_count;

endmodule

FILE: rtl/drb_fifo.sv
// Short queue of classified words between front and back.
module drb_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  drb_pkg::job_t wr_job,
  input  logic          rd,
  output logic          full,
  output logic          not_empty,
  output drb_pkg::job_t rd_job
);

  localparam int PW = $clog2(drb_pkg::QDEPTH);

  drb_pkg::job_t slots [drb_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full      = fill == (PW+1)'(drb_pkg::QDEPTH);
  assign not_empty = fill != '0;
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(drb_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(drb_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({wr, rd})
        2'b10:   fill <= fill + (PW+1)'(1);
        2'b01:   fill <= fill - (PW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/drb_back.sv
// Back end: carries out one word at a time on the ring store and builds the result.
module drb_back #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  drb_pkg::job_t job,
  input  logic [31:0]   default_value,
  output logic          job_take,
  output logic          strobe,
  output drb_pkg::out_t result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = (CW > 7) ? CW : 7;
  localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [TW-1:0] off);
    logic [TW:0] s;
    s = (TW+1)'(h) + (TW+1)'(off);
    if (s >= (TW+1)'(CAPACITY)) begin
      s = s - (TW+1)'(CAPACITY);
    end
    return AW'(s);
  endfunction

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_b;

  drb_pkg::bst_t state;
  drb_pkg::bst_t state_next;
  drb_pkg::job_t cur;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] tgt;
  logic          under;
  logic          over;
  logic [31:0]   fv;
  logic [31:0]   bv;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] head_dec;
  logic [TW-1:0] nc;
  logic          tgt_over;
  logic [TW-1:0] tgt_c;
  logic          is_full;

  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
  assign nc       = TW'(cur.new_count);
  assign tgt_over = nc > CAP_T;
  assign tgt_c    = tgt_over ? CAP_T : nc;
  assign is_full  = count == CW'(CAPACITY);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      drb_pkg::B_IDLE: begin
        if (job_valid) begin
          state_next = drb_pkg::B_EXEC;
        end
      end
      drb_pkg::B_EXEC: begin
        if (cur.cls.rsz && TW'(count) < tgt_c) begin
          state_next = drb_pkg::B_FILL;
        end else begin
          state_next = drb_pkg::B_READ;
        end
      end
      drb_pkg::B_FILL: begin
        if ((count + CW'(1)) == tgt) begin
          state_next = drb_pkg::B_READ;
        end
      end
      drb_pkg::B_READ: state_next = drb_pkg::B_CAPT;
      drb_pkg::B_CAPT: state_next = drb_pkg::B_EMIT;
      drb_pkg::B_EMIT: state_next = drb_pkg::B_IDLE;
      default:         state_next = drb_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_take = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = slot_of(head, TW'(count));
    addr_a   = head;
    addr_b   = slot_of(head, TW'(count) - TW'(1));
    case (state)
      drb_pkg::B_IDLE: begin
        job_take = job_valid;
      end
      drb_pkg::B_EXEC: begin
        wr_en = cur.cls.push && !is_full;
        if (cur.cls.at_front) begin
          wr_addr = head_dec;
        end
      end
      drb_pkg::B_FILL: begin
        wr_en = 1'b1;
      end
      drb_pkg::B_CAPT: begin
        addr_a = slot_of(head, TW'(cur.index));
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cur.value;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= drb_pkg::B_IDLE;
      head   <= '0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= state == drb_pkg::B_EMIT;
      case (state)
        drb_pkg::B_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            under <= 1'b0;
            over  <= 1'b0;
          end
        end
        drb_pkg::B_EXEC: begin
          if (cur.cls.push) begin
            if (is_full) begin
              over <= 1'b1;
            end else begin
              count <= count + CW'(1);
              if (cur.cls.at_front) begin
                head <= head_dec;
              end
            end
          end else if (cur.cls.pop) begin
            if (count == '0) begin
              under <= 1'b1;
            end else begin
              count <= count - CW'(1);
              if (count == CW'(1)) begin
                head <= '0;
              end else if (cur.cls.at_front) begin
                head <= slot_of(head, TW'(1));
              end
            end
          end else if (cur.cls.clr) begin
            head  <= '0;
            count <= '0;
          end else if (cur.cls.rsz) begin
            over <= tgt_over;
            tgt  <= CW'(tgt_c);
            if (TW'(count) > tgt_c) begin
              count <= CW'(tgt_c);
              if (tgt_c == '0) begin
                head <= '0;
              end
            end
          end
        end
        drb_pkg::B_FILL: begin
          count <= count + CW'(1);
        end
        drb_pkg::B_CAPT: begin
          fv <= rdata_a;
          bv <= rdata_b;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == drb_pkg::B_EMIT) begin
      result.read_value  <= (cur.cls.rd && TW'(cur.index) < TW'(count)) ? rdata_a
                                                                        : default_value;
      result.front_value <= (count != '0) ? fv : default_value;
      result.back_value  <= (count != '0) ? bv : default_value;
      result.count       <= 7'(count);
      result.is_empty    <= count == '0;
      result.is_full     <= is_full;
      result.underflow   <= under;
      result.overflow    <= over;
    end
  end

endmodule

FILE: rtl/deque_ring_buffer_core.sv
// Top level of the deque ring buffer core.
//
//  channel   direction  signals                      handshake
//  command   in         start, busy, request         taken when start && !busy
//  result    out        strobe, result               one cycle, no back-pressure
//  config    in         cfg_we, cfg_data             written when cfg_we
//
// In the back end a word is taken, executed, read twice from the ring store
// and emitted; a growing resize first appends its elements in a fill state.
// The result appears the cycle after emit; the two-entry queue takes new
// words while the back end works, and busy is high only when it is full.
// Reset clears the pointers, count and default register; store contents
// stay undefined until written.
module deque_ring_buffer_core #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  drb_pkg::in_t  request,
  output logic          strobe,
  output drb_pkg::out_t result,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data
);

  logic [31:0]   default_value;
  logic          q_wr;
  logic          q_full;
  logic          q_not_empty;
  logic          q_rd;
  drb_pkg::job_t wr_job;
  drb_pkg::job_t rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= '0;
    end else if (cfg_we) begin
      default_value <= cfg_data;
    end
  end

  drb_front u_front (
    .start   (start),
    .request (request),
    .q_full  (q_full),
    .busy    (busy),
    .q_wr    (q_wr),
    .job     (wr_job)
  );

  drb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .wr_job    (wr_job),
    .rd        (q_rd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_job    (rd_job)
  );

  drb_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (q_not_empty),
    .job           (rd_job),
    .default_value (default_value),
    .job_take      (q_rd),
    .strobe        (strobe),
    .result        (result)
  );

endmodule

FILE: rtl/drb_checker.sv
// Port-level checks for the deque ring buffer core, bound to the top level.
module drb_checker (
  input logic          clk,
  input logic          rst,
  input logic          strobe,
  input drb_pkg::out_t result
);

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe held for more than one cycle");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.is_empty) |-> (result.count == 7'd0))
    else $error("empty reported with non-zero count");

  a_empty_default: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.is_empty) |-> (result.front_value == result.back_value))
    else $error("empty deque reports differing front and back");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.underflow) |-> (result.is_empty && !result.overflow && !result.is_full))
    else $error("underflow on a non-empty deque");

endmodule

bind deque_ring_buffer_core drb_checker u_drb_checker (
  .clk    (clk),
  .rst    (rst),
  .strobe (strobe),
  .result (result)
);

FILE: dv/deque_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the deque ring buffer core: tracks the deque, predicts each result word, compares.
module deque_checker #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  drb_pkg::in_t  request,
  input  logic          strobe,
  input  drb_pkg::out_t result,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data,
  output int            errors,
  output int            pending
);

  logic [31:0]   ring [CAPACITY];
  int unsigned   head;
  int unsigned   fill;
  logic [31:0]   dflt;
  drb_pkg::out_t expected_q[$];
  int            mismatches = 0;
  int            outstanding = 0;

  assign errors  = mismatches;
  assign pending = outstanding;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 200)
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic cmp_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  function automatic int unsigned slot_at(int unsigned off);
    int unsigned s;
    s = head + off;
    if (s >= CAPACITY) s -= CAPACITY;
    return s;
  endfunction

  // Applies one command word to the tracked deque and returns the word the block should emit.
  function automatic drb_pkg::out_t apply_command(drb_pkg::in_t w);
    drb_pkg::out_t e;
    logic [31:0]   rd;
    logic          under;
    logic          over;
    int unsigned   tgt;
    rd    = dflt;
    under = 1'b0;
    over  = 1'b0;
    case (w.operation)
      drb_pkg::OP_PUSH_BACK: begin
        if (fill >= CAPACITY) begin
          over = 1'b1;
        end else begin
          ring[slot_at(fill)] = w.value;
          fill++;
        end
      end
      drb_pkg::OP_PUSH_FRONT: begin
        if (fill >= CAPACITY) begin
          over = 1'b1;
        end else begin
          head = (head == 0) ? CAPACITY - 1 : head - 1;
          ring[head] = w.value;
          fill++;
        end
      end
      drb_pkg::OP_POP_BACK: begin
        if (fill == 0) begin
          under = 1'b1;
        end else begin
          fill--;
          if (fill == 0) head = 0;
        end
      end
      drb_pkg::OP_POP_FRONT: begin
        if (fill == 0) begin
          under = 1'b1;
        end else begin
          head = slot_at(1);
          fill--;
          if (fill == 0) head = 0;
        end
      end
      drb_pkg::OP_READ: begin
        if (32'(w.index) < fill) rd = ring[slot_at(32'(w.index))];
      end
      drb_pkg::OP_CLEAR: begin
        head = 0;
        fill = 0;
      end
      drb_pkg::OP_RESIZE: begin
        tgt = 32'(w.new_count);
        if (tgt > CAPACITY) begin
          tgt  = CAPACITY;
          over = 1'b1;
        end
        while (fill < tgt) begin
          ring[slot_at(fill)] = w.value;
          fill++;
        end
        if (tgt < fill) fill = tgt;
        if (fill == 0) head = 0;
      end
      default: ;
    endcase
    e.read_value  = rd;
    e.front_value = (fill != 0) ? ring[head] : dflt;
    e.back_value  = (fill != 0) ? ring[slot_at(fill - 1)] : dflt;
    e.count       = fill[6:0];
    e.is_empty    = (fill == 0);
    e.is_full     = (fill == CAPACITY);
    e.underflow   = under;
    e.overflow    = over;
    return e;
  endfunction

  task automatic check_word(drb_pkg::out_t got);
    drb_pkg::out_t want;
    if (expected_q.size() == 0) begin
      report("unexpected word", 32'(got.count), 32'd0);
    end else begin
      want = expected_q[0];
      expected_q.delete(0);
      cmp_field("read_value", got.read_value, want.read_value);
      cmp_field("front_value", got.front_value, want.front_value);
      cmp_field("back_value", got.back_value, want.back_value);
      cmp_field("count", 32'(got.count), 32'(want.count));
      cmp_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
      cmp_field("is_full", 32'(got.is_full), 32'(want.is_full));
      cmp_field("underflow", 32'(got.underflow), 32'(want.underflow));
      cmp_field("overflow", 32'(got.overflow), 32'(want.overflow));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head = 0;
      fill = 0;
      dflt = '0;
      expected_q.delete();
    end else begin
      if (strobe) check_word(result);
      if (cfg_we) dflt = cfg_data;
      if (start && !busy) expected_q.insert(expected_q.size(), apply_command(request));
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the deque ring buffer testbench: clock, reset, command stimulus and verdict.
module testbench;

  localparam int DEPTH = 64;
  localparam logic [2:0] OP_SPARE = 3'd7;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  drb_pkg::in_t  request = '0;
  logic          strobe;
  drb_pkg::out_t result;
  logic          cfg_we = 1'b0;
  logic [31:0]   cfg_data = '0;
  int            errors;
  int            pending;

  always #10 clk = ~clk;

  deque_ring_buffer_core #(.CAPACITY(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  deque_checker #(.CAPACITY(DEPTH)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  task automatic issue(logic [2:0] op, logic [31:0] v, logic [5:0] idx, logic [6:0] n);
    start             <= 1'b1;
    request.operation <= op;
    request.value     <= v;
    request.index     <= idx;
    request.new_count <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Idle the command side until every outstanding word has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_default(logic [31:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mode 0 grows the deque, 1 shrinks it, 2 mixes
  function automatic logic [2:0] pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 40) return drb_pkg::OP_PUSH_BACK;
        if (r < 70) return drb_pkg::OP_PUSH_FRONT;
        if (r < 75) return drb_pkg::OP_POP_BACK;
        if (r < 80) return drb_pkg::OP_POP_FRONT;
        if (r < 92) return drb_pkg::OP_READ;
        if (r < 98) return drb_pkg::OP_RESIZE;
        if (r < 99) return drb_pkg::OP_CLEAR;
        return OP_SPARE;
      end
      1: begin
        if (r < 12) return drb_pkg::OP_PUSH_BACK;
        if (r < 22) return drb_pkg::OP_PUSH_FRONT;
        if (r < 47) return drb_pkg::OP_POP_BACK;
        if (r < 72) return drb_pkg::OP_POP_FRONT;
        if (r < 88) return drb_pkg::OP_READ;
        if (r < 94) return drb_pkg::OP_RESIZE;
        if (r < 97) return drb_pkg::OP_CLEAR;
        return OP_SPARE;
      end
      default: begin
        if (r < 20) return drb_pkg::OP_PUSH_BACK;
        if (r < 35) return drb_pkg::OP_PUSH_FRONT;
        if (r < 50) return drb_pkg::OP_POP_BACK;
        if (r < 65) return drb_pkg::OP_POP_FRONT;
        if (r < 90) return drb_pkg::OP_READ;
        if (r < 96) return drb_pkg::OP_RESIZE;
        if (r < 98) return drb_pkg::OP_CLEAR;
        return OP_SPARE;
      end
    endcase
  endfunction

  task automatic random_phase(int n_words);
    int          mode;
    int          seg_left;
    int          burst_left;
    logic [5:0]  idx;
    logic [6:0]  n;
    mode       = 2;
    seg_left   = 0;
    burst_left = $urandom_range(1, 20);
    for (int i = 0; i < n_words; i++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(60, 160);
      end
      seg_left--;
      idx = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 15))
                                        : 6'($urandom_range(0, 63));
      n   = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(0, 66));
      issue(pick_op(mode), rand_word(), idx, n);
      burst_left--;
      if (burst_left == 0) begin
        pause($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 20);
      end
    end
  endtask

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_default(32'h8000_0000);

    // empty deque, both ends, range edges, resize cases
    issue(drb_pkg::OP_POP_BACK, 32'h0, 6'd0, 7'd0);
    issue(drb_pkg::OP_POP_FRONT, 32'h0, 6'd0, 7'd0);
    issue(drb_pkg::OP_READ, 32'h0, 6'd0, 7'd0);
    issue(drb_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 6'd0, 7'd0);
    issue(drb_pkg::OP_PUSH_BACK, 32'h8000_0000, 6'd0, 7'd0);
    issue(drb_pkg::OP_READ, 32'h0, 6'd0, 7'd0);
    issue(drb_pkg::OP_READ, 32'h0, 6'd1, 7'd0);
    issue(drb_pkg::OP_READ, 32'h0, 6'd2, 7'd0);
    issue(drb_pkg::OP_READ, 32'h0, 6'd63, 7'd0);
    issue(OP_SPARE, 32'hFFFF_FFFF, 6'd63, 7'd127);
    issue(drb_pkg::OP_RESIZE, 32'hFFFF_FFFF, 6'd0, 7'd5);
    issue(drb_pkg::OP_RESIZE, 32'h0, 6'd0, 7'd3);
    issue(drb_pkg::OP_RESIZE, 32'h1234_5678, 6'd0, 7'd3);
    issue(drb_pkg::OP_RESIZE, 32'h5A5A_5A5A, 6'd0, 7'd127);
    issue(drb_pkg::OP_PUSH_BACK, 32'h1, 6'd0, 7'd0);
    issue(drb_pkg::OP_PUSH_FRONT, 32'h2, 6'd0, 7'd0);
    issue(drb_pkg::OP_READ, 32'h0, 6'd63, 7'd0);
    issue(drb_pkg::OP_RESIZE, 32'h0, 6'd0, 7'd0);
    issue(drb_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5, 6'd0, 7'd0);
    issue(drb_pkg::OP_POP_FRONT, 32'h0, 6'd0, 7'd0);
    issue(drb_pkg::OP_PUSH_FRONT, 32'h0000_0001, 6'd0, 7'd0);
    issue(drb_pkg::OP_POP_BACK, 32'h0, 6'd0, 7'd0);
    issue(drb_pkg::OP_RESIZE, 32'hC3C3_C3C3, 6'd0, 7'd64);
    issue(drb_pkg::OP_CLEAR, 32'h0, 6'd0, 7'd0);
    issue(drb_pkg::OP_READ, 32'h0, 6'd0, 7'd0);
    drain();

    set_default(32'h0000_0000);
    random_phase(200);
    drain();
    set_default(32'h7FFF_FFFF);
    random_phase(200);
    drain();
    set_default(32'hFFFF_FFFF);
    random_phase(200);
    drain();
    set_default($urandom);
    random_phase(200);
    drain();

    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: deque_ring_buffer_core.f
rtl/drb_pkg.sv
rtl/drb_front.sv
rtl/drb_fifo.sv
rtl/drb_back.sv
rtl/deque_ring_buffer_core.sv
rtl/drb_checker.sv
dv/deque_checker.sv
dv/testbench.sv
